// File: rtl/core/i2a_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2a_pkg: shared types and constants of the integer-to-ASCII formatter
// Conversion codes, queue item layout, sequencer states, character helpers.
// ----------------------------------------------------------------------------
package i2a_pkg;

	localparam int I2A_MAX_WIDTH     = 64;
	localparam int I2A_MAX_PRECISION = 32;

	// stream layout
	localparam int IN_DATA_W  = 88;
	localparam int IN_USER_W  = 4;
	localparam int OUT_DATA_W = 8;

	// character counts never exceed 64, precision plus digits stays below 64
	localparam int CNT_W = 7;

	// digit store: 22 octal digits cover 64 bits, 20 BCD digits for decimal
	localparam int NUM_DIGITS  = 22;
	localparam int DIG_IDX_W   = $clog2(NUM_DIGITS);
	localparam int BCD_DIGITS  = 20;
	localparam int BCD_W       = 4 * BCD_DIGITS;
	localparam int CONV_STEPS  = 32;
	localparam int CONV_CNT_W  = $clog2(CONV_STEPS);

	localparam int Q_DEPTH = 2;

	// conversion kinds
	localparam logic [2:0] CMD_SDEC   = 3'd0;
	localparam logic [2:0] CMD_UDEC   = 3'd1;
	localparam logic [2:0] CMD_OCT    = 3'd2;
	localparam logic [2:0] CMD_HEX_LO = 3'd3;
	localparam logic [2:0] CMD_HEX_UP = 3'd4;

	// ASCII codes
	localparam logic [6:0] CH_SPACE = 7'h20;
	localparam logic [6:0] CH_PLUS  = 7'h2B;
	localparam logic [6:0] CH_MINUS = 7'h2D;
	localparam logic [6:0] CH_ZERO  = 7'h30;
	localparam logic [6:0] CH_A_UP  = 7'h41;
	localparam logic [6:0] CH_X_UP  = 7'h58;
	localparam logic [6:0] CH_A_LO  = 7'h61;
	localparam logic [6:0] CH_X_LO  = 7'h78;

	typedef enum logic [1:0] {
		RADIX_DEC,
		RADIX_OCT,
		RADIX_HEX
	} radix_t;

	typedef enum logic [1:0] {
		SGN_NONE,
		SGN_MINUS,
		SGN_PLUS,
		SGN_SPACE
	} sign_t;

	typedef struct packed {
		logic [63:0] mag;
		logic        nonzero;
		sign_t       sign;
		radix_t      radix;
		logic        upper;
		logic        alt;
		logic        left;
		logic        zero;
		logic [6:0]  width;
		logic [5:0]  prec;
	} item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_COUNT,
		ST_BODY,
		ST_LAYOUT,
		ST_EMIT
	} back_state_t;

	function automatic logic [6:0] digit_char(input logic [3:0] d, input logic upper);
		logic [6:0] c;
		if (d < 4'd10)
			c = CH_ZERO + 7'(d);
		else if (upper)
			c = CH_A_UP + 7'(d - 4'd10);
		else
			c = CH_A_LO + 7'(d - 4'd10);
		return c;
	endfunction

	// one double-dabble step: adjust every BCD digit, then shift in one bit
	function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
		input logic bit_in);
		logic [BCD_W-1:0] adj;
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (bcd[4*i +: 4] >= 4'd5)
				adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
			else
				adj[4*i +: 4] = bcd[4*i +: 4];
		end
		return {adj[BCD_W-2:0], bit_in};
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/integer_to_ascii_formatter_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_top: printf-style integer formatter
// One conversion request in, its ASCII characters out, one per beat.
// ----------------------------------------------------------------------------
// A request is taken into an intake register and a two-deep queue, so up to
// three requests can wait while one is being formatted. The sequencer handles
// one request at a time: decimal kinds pass through the double-dabble
// converter (two bits per cycle), octal and hex skip it; sizing runs
// through the count, body and layout states; then one character leaves per
// cycle while the output is taken. A request yields 1 to MAX_WIDTH characters,
// and the sequencer returns to idle between requests. tlast marks the final
// character of each request.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_top import i2a_pkg::*; #(
	parameter int MAX_WIDTH     = I2A_MAX_WIDTH,
	parameter int MAX_PRECISION = I2A_MAX_PRECISION
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// value[63:0], alt_form, space_sign, left_align, plus_sign, zero_pad,
	// field_width[6:0], min_digits[5:0], zero fill
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// cmd[2:0], wide
	input  logic [IN_USER_W-1:0]  s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// char_code[6:0], zero fill
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic                  m_axis_tlast
);

	logic       push_valid;
	logic       push_ready;
	item_t      push_item;
	logic       pop_valid;
	logic       pop_ready;
	item_t      pop_item;
	logic [6:0] char_code;

	i2a_front #(
		.MAX_WIDTH     (MAX_WIDTH),
		.MAX_PRECISION (MAX_PRECISION)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_data    (s_axis_tdata),
		.in_user    (s_axis_tuser),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	i2a_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	i2a_back #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_char  (char_code),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {1'b0, char_code};

endmodule
`default_nettype wire

// File: rtl/core/i2a_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2a_front: request intake
// Unpacks a request beat, picks the magnitude, sign and radix, saturates
// width and precision, and hands the result to the queue.
// ----------------------------------------------------------------------------
module i2a_front import i2a_pkg::*; #(
	parameter int MAX_WIDTH     = I2A_MAX_WIDTH,
	parameter int MAX_PRECISION = I2A_MAX_PRECISION
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [IN_DATA_W-1:0] in_data,
	input  logic [IN_USER_W-1:0] in_user,
	output logic                 push_valid,
	input  logic                 push_ready,
	output item_t                push_item
);

	logic [2:0]  cmd;
	logic        wide;
	logic [63:0] value;
	logic [63:0] raw;
	logic [63:0] sext;
	logic [6:0]  fw;
	logic [5:0]  md;
	item_t       item_d;
	item_t       item_s1;
	logic        valid_s1;
	logic        take;

	assign cmd   = in_user[2:0];
	assign wide  = in_user[3];
	assign value = in_data[63:0];
	assign fw    = in_data[75:69];
	assign md    = in_data[81:76];

	assign raw  = wide ? value : {32'd0, value[31:0]};
	assign sext = wide ? value : {{32{value[31]}}, value[31:0]};

	always_comb begin
		item_d       = '0;
		item_d.alt   = in_data[64];
		item_d.left  = in_data[66];
		item_d.zero  = in_data[68];
		item_d.width = (fw > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : fw;
		item_d.prec  = (md > 6'(MAX_PRECISION)) ? 6'(MAX_PRECISION) : md;
		item_d.sign  = SGN_NONE;
		item_d.radix = RADIX_DEC;
		item_d.mag   = raw;
		case (cmd)
			CMD_SDEC: begin
				item_d.mag = sext[63] ? (64'd0 - sext) : sext;
				if (sext[63])
					item_d.sign = SGN_MINUS;
				else if (in_data[67])
					item_d.sign = SGN_PLUS;
				else if (in_data[65])
					item_d.sign = SGN_SPACE;
			end
			CMD_OCT:    item_d.radix = RADIX_OCT;
			CMD_HEX_LO: item_d.radix = RADIX_HEX;
			CMD_HEX_UP: begin
				item_d.radix = RADIX_HEX;
				item_d.upper = 1'b1;
			end
			// unsigned decimal, and unknown kinds read as unsigned decimal
			default:    item_d.radix = RADIX_DEC;
		endcase
		item_d.nonzero = |item_d.mag;
	end

	assign in_ready   = !valid_s1 || push_ready;
	assign take       = in_valid && in_ready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item_d;
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/i2a_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2a_queue: request queue
// Two-entry FIFO of classified requests between intake and sequencer.
// ----------------------------------------------------------------------------
module i2a_queue import i2a_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  item_t push_item,
	output logic  pop_valid,
	input  logic  pop_ready,
	output item_t pop_item
);

	localparam int PTR_W = $clog2(Q_DEPTH);
	localparam int CNT_QW = $clog2(Q_DEPTH + 1);

	item_t              slot_q [Q_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_QW-1:0]  count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (count_q != CNT_QW'(Q_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/i2a_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2a_back: digit conversion and character sequencer
// Splits the magnitude into digits (double dabble for decimal, slicing for
// octal and hex), sizes the fields, then emits one character per beat.
// ----------------------------------------------------------------------------
module i2a_back import i2a_pkg::*; #(
	parameter int MAX_WIDTH = I2A_MAX_WIDTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pop_valid,
	output logic       pop_ready,
	input  item_t      pop_item,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [6:0] out_char,
	output logic       out_last
);

	back_state_t           state_q;
	back_state_t           state_d;

	item_t                 item_q;
	logic [3:0]            dig_q [NUM_DIGITS];
	logic [BCD_W-1:0]      bcd_q;
	logic [BCD_W-1:0]      bcd_next;
	logic [63:0]           shift_q;
	logic [CONV_CNT_W-1:0] cnt_q;

	logic [CNT_W-1:0]      ndig_q;
	logic [CNT_W-1:0]      zeros_q;
	logic [1:0]            pfx_q;
	logic                  sgn_q;
	logic [CNT_W-1:0]      body_q;
	logic [CNT_W-1:0]      b1_q, b2_q, b3_q, b4_q, b5_q;
	logic [CNT_W-1:0]      last_idx_q;
	logic [CNT_W-1:0]      n_q;

	logic                  out_valid_q;
	logic [6:0]            out_char_q;
	logic                  out_last_q;

	logic                  out_free;
	logic                  emit;
	logic                  conv_done;

	logic [CNT_W-1:0]      ndig_v;
	logic [CNT_W-1:0]      zeros_v;
	logic [1:0]            pfx_v;
	logic [CNT_W-1:0]      body_v;
	logic [CNT_W-1:0]      pad_v, lead_v, zpad_v;
	logic [CNT_W-1:0]      b2_v, b3_v, b4_v;
	logic [CNT_W-1:0]      total_full_v, total_v;
	logic [CNT_W-1:0]      didx_v;
	logic [6:0]            char_v;
	logic [65:0]           oct_src;
	logic [87:0]           hex_src;

	assign out_free  = !out_valid_q || out_ready;
	assign conv_done = (cnt_q == CONV_CNT_W'(CONV_STEPS - 1));
	assign bcd_next  = dabble_step(dabble_step(bcd_q, shift_q[63]), shift_q[62]);
	assign oct_src   = {2'b00, pop_item.mag};
	assign hex_src   = {24'd0, pop_item.mag};

	// sequencer next state
	always_comb begin
		state_d   = state_q;
		pop_ready = 1'b0;
		emit      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid)
					state_d = (pop_item.radix == RADIX_DEC) ? ST_CONV : ST_COUNT;
			end
			ST_CONV: begin
				if (conv_done)
					state_d = ST_COUNT;
			end
			ST_COUNT:  state_d = ST_BODY;
			ST_BODY:   state_d = ST_LAYOUT;
			ST_LAYOUT: state_d = ST_EMIT;
			ST_EMIT: begin
				emit = out_free;
				if (out_free && n_q == last_idx_q)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// significant digit count: highest nonzero digit, at least one
	always_comb begin
		ndig_v = CNT_W'(1);
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (dig_q[i] != 4'd0)
				ndig_v = CNT_W'(i + 1);
		end
	end

	// precision zeros, prefix and body length
	always_comb begin
		zeros_v = (CNT_W'(item_q.prec) > ndig_q) ? CNT_W'(item_q.prec) - ndig_q : '0;
		if (item_q.alt && item_q.radix == RADIX_OCT && zeros_v == '0 && item_q.nonzero)
			zeros_v = CNT_W'(1);
		pfx_v  = (item_q.alt && item_q.radix == RADIX_HEX && item_q.nonzero) ? 2'd2 : 2'd0;
		body_v = CNT_W'(item_q.sign != SGN_NONE) + CNT_W'(pfx_v) + zeros_v + ndig_q;
	end

	// segment boundaries and output length
	always_comb begin
		pad_v        = (CNT_W'(item_q.width) > body_q) ? CNT_W'(item_q.width) - body_q : '0;
		lead_v       = (!item_q.left && !item_q.zero) ? pad_v : '0;
		zpad_v       = (!item_q.left && item_q.zero) ? pad_v : '0;
		b2_v         = lead_v + CNT_W'(sgn_q);
		b3_v         = b2_v + CNT_W'(pfx_q);
		b4_v         = b3_v + zpad_v + zeros_q;
		total_full_v = (CNT_W'(item_q.width) > body_q) ? CNT_W'(item_q.width) : body_q;
		total_v      = (total_full_v > CNT_W'(MAX_WIDTH)) ? CNT_W'(MAX_WIDTH) : total_full_v;
	end

	// character at position n_q
	always_comb begin
		didx_v = b5_q - CNT_W'(1) - n_q;
		if (n_q < b1_q) begin
			char_v = CH_SPACE;
		end else if (n_q < b2_q) begin
			case (item_q.sign)
				SGN_MINUS: char_v = CH_MINUS;
				SGN_PLUS:  char_v = CH_PLUS;
				default:   char_v = CH_SPACE;
			endcase
		end else if (n_q < b3_q) begin
			if (n_q == b2_q)
				char_v = CH_ZERO;
			else
				char_v = item_q.upper ? CH_X_UP : CH_X_LO;
		end else if (n_q < b4_q) begin
			char_v = CH_ZERO;
		end else if (n_q < b5_q) begin
			char_v = digit_char(dig_q[didx_v[DIG_IDX_W-1:0]], item_q.upper);
		end else begin
			char_v = CH_SPACE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop_valid) begin
					item_q  <= pop_item;
					bcd_q   <= '0;
					shift_q <= pop_item.mag;
					cnt_q   <= '0;
					for (int i = 0; i < NUM_DIGITS; i++) begin
						if (pop_item.radix == RADIX_OCT)
							dig_q[i] <= {1'b0, oct_src[3*i +: 3]};
						else if (pop_item.radix == RADIX_HEX)
							dig_q[i] <= hex_src[4*i +: 4];
						else
							dig_q[i] <= 4'd0;
					end
				end
			end
			ST_CONV: begin
				bcd_q   <= bcd_next;
				shift_q <= {shift_q[61:0], 2'b00};
				cnt_q   <= cnt_q + 1'b1;
				if (conv_done) begin
					for (int i = 0; i < NUM_DIGITS; i++) begin
						if (i < BCD_DIGITS)
							dig_q[i] <= bcd_next[4*i +: 4];
						else
							dig_q[i] <= 4'd0;
					end
				end
			end
			ST_COUNT: begin
				ndig_q <= ndig_v;
			end
			ST_BODY: begin
				zeros_q <= zeros_v;
				pfx_q   <= pfx_v;
				sgn_q   <= (item_q.sign != SGN_NONE);
				body_q  <= body_v;
			end
			ST_LAYOUT: begin
				b1_q       <= lead_v;
				b2_q       <= b2_v;
				b3_q       <= b3_v;
				b4_q       <= b4_v;
				b5_q       <= b4_v + ndig_q;
				last_idx_q <= total_v - CNT_W'(1);
				n_q        <= '0;
			end
			ST_EMIT: begin
				if (emit) begin
					out_char_q <= char_v;
					out_last_q <= (n_q == last_idx_q);
					n_q        <= n_q + 1'b1;
				end
			end
			default: begin
				n_q <= '0;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;

endmodule
`default_nettype wire

// File: rtl/core/i2a_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2a_assertions: port-level checks for the formatter
// Watches the stream ports: stall behavior, character set, frame length and
// that no character appears without a request behind it.
// ----------------------------------------------------------------------------
module i2a_assertions import i2a_pkg::*; #(
	parameter int MAX_WIDTH = I2A_MAX_WIDTH
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_axis_tvalid,
	input wire logic                  s_axis_tready,
	input wire logic                  m_axis_tvalid,
	input wire logic                  m_axis_tready,
	input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
	input wire logic                  m_axis_tlast
);

	localparam int BEAT_W = $clog2(MAX_WIDTH + 1);

	logic [BEAT_W-1:0] beats_q;
	logic [3:0]        pend_q;
	logic              in_beat;
	logic              out_beat;
	logic [6:0]        ch;

	assign in_beat  = s_axis_tvalid && s_axis_tready;
	assign out_beat = m_axis_tvalid && m_axis_tready;
	assign ch       = m_axis_tdata[6:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beats_q <= '0;
			pend_q  <= '0;
		end else begin
			if (out_beat)
				beats_q <= m_axis_tlast ? '0 : beats_q + 1'b1;
			if (in_beat && !(out_beat && m_axis_tlast))
				pend_q <= pend_q + 1'b1;
			else if (!in_beat && out_beat && m_axis_tlast)
				pend_q <= pend_q - 1'b1;
		end
	end

	// hold a stalled beat
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled output beat changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[7] == 1'b0 &&
			(ch == CH_SPACE || ch == CH_PLUS || ch == CH_MINUS ||
			 (ch >= CH_ZERO && ch <= 7'h39) ||
			 (ch >= CH_A_UP && ch <= 7'h46) || ch == CH_X_UP ||
			 (ch >= CH_A_LO && ch <= 7'h66) || ch == CH_X_LO))
		else $error("character outside the formatter's set");

	// cap a request at MAX_WIDTH characters
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && beats_q == BEAT_W'(MAX_WIDTH - 1) |-> m_axis_tlast)
		else $error("request ran past the character limit");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> pend_q != 4'd0)
		else $error("character with no request outstanding");

endmodule

bind integer_to_ascii_formatter_top i2a_assertions #(
	.MAX_WIDTH (MAX_WIDTH)
) u_i2a_assertions (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

// File: tb/i2a_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2a_checker: scoreboard for the integer-to-ASCII formatter
// Formats every accepted request in software, queues the characters it should
// produce and compares each output beat, character and end mark, in order.
// ----------------------------------------------------------------------------
module i2a_checker import i2a_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  logic [IN_USER_W-1:0]  s_axis_tuser,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                  m_axis_tlast,
	output int                    mismatches,
	output int                    chars_pending
);

	typedef struct packed {
		logic [6:0] code;
		logic       last;
	} char_beat_t;

	char_beat_t expected_chars[$];

	// lay out one request the way the formatter should and queue its characters
	function automatic void format_request(input logic [IN_DATA_W-1:0] d,
		input logic [IN_USER_W-1:0] u);
		logic [2:0]  kind;
		logic [63:0] raw;
		logic [63:0] mag;
		logic        wide, alt, fspace, fleft, fplus, fzero, neg, upper, has_sign;
		logic [3:0]  d4;
		logic [6:0]  sign_ch;
		logic [6:0]  digits [64];
		logic [6:0]  line [$];
		char_beat_t  beat;
		int          width, prec, radix, ndig, zeros, body, pad, pfx_len, i;

		raw    = d[63:0];
		alt    = d[64];
		fspace = d[65];
		fleft  = d[66];
		fplus  = d[67];
		fzero  = d[68];
		width  = int'(d[75:69]);
		prec   = int'(d[81:76]);
		kind   = u[2:0];
		wide   = u[3];

		if (width > I2A_MAX_WIDTH)
			width = I2A_MAX_WIDTH;
		if (prec > I2A_MAX_PRECISION)
			prec = I2A_MAX_PRECISION;
		if (kind > CMD_HEX_UP)
			kind = CMD_UDEC;
		if (!wide)
			raw[63:32] = '0;

		has_sign = 1'b0;
		sign_ch  = CH_SPACE;
		radix    = 10;
		upper    = (kind == CMD_HEX_UP);
		if (kind == CMD_SDEC) begin
			neg = wide ? raw[63] : raw[31];
			if (!wide && neg)
				raw[63:32] = '1;
			mag = neg ? (~raw + 64'd1) : raw;
			if (neg) begin
				has_sign = 1'b1;
				sign_ch  = CH_MINUS;
			end else if (fplus) begin
				has_sign = 1'b1;
				sign_ch  = CH_PLUS;
			end else if (fspace) begin
				has_sign = 1'b1;
				sign_ch  = CH_SPACE;
			end
		end else begin
			mag = raw;
			if (kind == CMD_OCT)
				radix = 8;
			else if (kind >= CMD_HEX_LO)
				radix = 16;
		end

		// digits come out least significant first
		ndig = 0;
		do begin
			d4 = 4'(mag % 64'(radix));
			if (d4 < 4'd10)
				digits[ndig] = CH_ZERO + 7'(d4);
			else
				digits[ndig] = (upper ? CH_A_UP : CH_A_LO) + 7'(d4 - 4'd10);
			ndig++;
			mag = mag / 64'(radix);
		end while (mag != 64'd0);

		zeros   = (prec > ndig) ? prec - ndig : 0;
		pfx_len = 0;
		if (alt && radix == 8) begin
			if (zeros == 0 && digits[ndig-1] != CH_ZERO)
				zeros = 1;
		end else if (alt && radix == 16 && raw != 64'd0) begin
			pfx_len = 2;
		end

		body = int'(has_sign) + pfx_len + zeros + ndig;
		pad  = (width > body) ? width - body : 0;

		if (!fleft && !fzero)
			repeat (pad) line.push_back(CH_SPACE);
		if (has_sign)
			line.push_back(sign_ch);
		if (pfx_len != 0) begin
			line.push_back(CH_ZERO);
			line.push_back(upper ? CH_X_UP : CH_X_LO);
		end
		if (!fleft && fzero)
			repeat (pad) line.push_back(CH_ZERO);
		repeat (zeros) line.push_back(CH_ZERO);
		for (i = ndig - 1; i >= 0; i--)
			line.push_back(digits[i]);
		if (fleft)
			repeat (pad) line.push_back(CH_SPACE);

		for (i = 0; i < line.size(); i++) begin
			beat.code = line[i];
			beat.last = (i == line.size() - 1);
			expected_chars.push_back(beat);
		end
	endfunction

	always @(posedge clk) begin
		char_beat_t want;
		if (!arst_n) begin
			mismatches = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				format_request(s_axis_tdata, s_axis_tuser);
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_chars.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected character 0x%02h last %0b", $realtime,
							m_axis_tdata[6:0], m_axis_tlast);
				end else begin
					want = expected_chars.pop_front();
					if (m_axis_tdata[6:0] !== want.code || m_axis_tlast !== want.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: character expected 0x%02h last %0b, got 0x%02h last %0b",
								$realtime, want.code, want.last, m_axis_tdata[6:0], m_axis_tlast);
					end
				end
			end
		end
		chars_pending <= expected_chars.size();
	end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the integer-to-ASCII formatter
// Sends directed corner requests and then random ones with random gaps on both
// streams, including one long output stall; the checker scores every beat.
// ----------------------------------------------------------------------------
module tb import i2a_pkg::*; ();

	localparam int          NUM_RANDOM       = 300;
	localparam int          CYCLE_LIMIT      = 400000;
	localparam int          HOLD_CYCLES      = 500;
	localparam logic [2:0]  CMD_UNUSED_FIRST = CMD_HEX_UP + 3'd1;
	localparam logic [2:0]  CMD_UNUSED_LAST  = 3'd7;

	typedef struct packed {
		logic [IN_DATA_W-1:0] data;
		logic [IN_USER_W-1:0] user;
	} request_t;

	logic                  clk;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
	logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tlast;

	logic calm     = 1'b0;
	logic hold_out = 1'b0;
	int   items_sent = 0;
	int   cycles     = 0;
	int   mismatches;
	int   chars_pending;

	integer_to_ascii_formatter_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	i2a_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.mismatches    (mismatches),
		.chars_pending (chars_pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("integer_to_ascii_formatter_top verification failed");
				$finish;
			end
		end
	end

	function automatic request_t make_request(input logic [2:0] cmd, input logic [63:0] value,
		input int wide, input int alt, input int space, input int left,
		input int plus, input int zero, input int width, input int prec);
		request_t r;
		r.data = {6'b0, 6'(prec), 7'(width), 1'(zero), 1'(plus), 1'(left), 1'(space),
			1'(alt), value};
		r.user = {1'(wide), cmd};
		return r;
	endfunction

	function automatic logic [63:0] random_value();
		case ($urandom_range(4))
			0: return {$urandom, $urandom};
			1: return 64'($urandom_range(20));
			2: return ~64'($urandom_range(20));
			3: return {$urandom, $urandom} >> $urandom_range(63);
			default: begin
				case ($urandom_range(5))
					0: return 64'd0;
					1: return '1;
					2: return 64'h0000_0000_8000_0000;
					3: return 64'h0000_0000_7FFF_FFFF;
					4: return 64'h8000_0000_0000_0000;
					default: return 64'h7FFF_FFFF_FFFF_FFFF;
				endcase
			end
		endcase
	endfunction

	function automatic request_t random_request();
		logic [2:0] cmd;
		int         width;
		int         prec;
		int         r;
		if ($urandom_range(99) < 6)
			cmd = 3'($urandom_range(CMD_UNUSED_LAST, CMD_UNUSED_FIRST));
		else
			cmd = 3'($urandom_range(CMD_HEX_UP, CMD_SDEC));
		r = $urandom_range(9);
		width = (r < 7) ? $urandom_range(20) :
			(r < 9) ? $urandom_range(64, 21) : $urandom_range(127, 65);
		r = $urandom_range(9);
		prec = (r < 7) ? $urandom_range(10) :
			(r < 9) ? $urandom_range(32, 11) : $urandom_range(63, 33);
		return make_request(cmd, random_value(), $urandom_range(1), $urandom_range(1),
			$urandom_range(1), $urandom_range(1), $urandom_range(1),
			$urandom_range(1), width, prec);
	endfunction

	// offer one beat after an optional random gap; return once it is taken
	task automatic send_request(input request_t r);
		while (!calm && $urandom_range(99) < 27) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= r.data;
		s_axis_tuser  <= r.user;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (!arst_n || hold_out)
				m_axis_tready <= 1'b0;
			else
				m_axis_tready <= calm || ($urandom_range(99) >= 27);
		end
	end

	// stall the output long enough for the request buffer to fill up
	initial begin
		wait (items_sent >= 60);
		@(posedge clk);
		hold_out <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_out <= 1'b0;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// cmd, value, wide, alt, space, left, plus, zero, width, prec
		send_request(make_request(CMD_SDEC, 64'd0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_request(make_request(CMD_SDEC, 64'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0));
		send_request(make_request(CMD_SDEC, 64'h8000_0000_0000_0000, 1, 0, 0, 0, 0, 0, 0, 0));
		send_request(make_request(CMD_SDEC, 64'h8000_0000, 0, 0, 0, 0, 0, 1, 15, 0));
		send_request(make_request(CMD_SDEC, 64'd42, 1, 0, 0, 0, 1, 0, 6, 0));
		send_request(make_request(CMD_SDEC, 64'd42, 1, 0, 1, 0, 0, 0, 6, 4));
		send_request(make_request(CMD_SDEC, 64'd42, 1, 0, 1, 0, 1, 1, 8, 0));
		send_request(make_request(CMD_UDEC, '1, 1, 0, 1, 0, 1, 0, 0, 0));
		send_request(make_request(CMD_UDEC, 64'hDEAD_BEEF_FFFF_FFFF, 0, 1, 0, 0, 0, 0, 12, 0));
		send_request(make_request(CMD_OCT, 64'd8, 1, 1, 0, 0, 0, 0, 0, 0));
		send_request(make_request(CMD_OCT, 64'd0, 1, 1, 0, 0, 0, 0, 0, 0));
		send_request(make_request(CMD_OCT, 64'd8, 1, 1, 0, 0, 0, 0, 0, 5));
		send_request(make_request(CMD_OCT, '1, 1, 1, 0, 1, 0, 0, 30, 0));
		send_request(make_request(CMD_HEX_LO, 64'hFF, 1, 1, 0, 0, 1, 0, 0, 0));
		send_request(make_request(CMD_HEX_LO, 64'd0, 1, 1, 0, 0, 0, 0, 4, 0));
		send_request(make_request(CMD_HEX_UP, 64'hABCD_EF01, 0, 1, 0, 0, 0, 1, 12, 0));
		send_request(make_request(CMD_HEX_UP, '1, 1, 1, 0, 0, 0, 0, 0, 0));
		send_request(make_request(CMD_UNUSED_FIRST, 64'hFFFF_FFFF_8000_0000, 0, 0, 1, 0, 1, 0,
			0, 0));
		send_request(make_request(CMD_UNUSED_LAST, '1, 1, 1, 0, 0, 0, 0, 0, 0));
		send_request(make_request(CMD_SDEC, 64'h8000_0000_0000_0000, 1, 1, 1, 1, 1, 1, 127, 63));
		send_request(make_request(CMD_HEX_LO, 64'h1234, 1, 1, 0, 1, 0, 1, 10, 0));
		send_request(make_request(CMD_UDEC, 64'd0, 1, 0, 0, 0, 0, 0, 64, 0));
		send_request(make_request(CMD_SDEC, 64'd7, 1, 0, 0, 1, 0, 0, 64, 32));

		for (int i = 0; i < NUM_RANDOM; i++) begin
			calm = (i >= 120 && i < 170);
			send_request(random_request());
		end
		calm = 1'b0;
		s_axis_tvalid <= 1'b0;

		// let the checker count the last request before draining
		@(posedge clk);
		while (chars_pending != 0) @(posedge clk);
		repeat (120) @(posedge clk);
		if (mismatches == 0)
			$display("integer_to_ascii_formatter_top verification clean");
		else
			$display("integer_to_ascii_formatter_top verification failed");
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/i2a_pkg.sv
rtl/core/i2a_front.sv
rtl/core/i2a_queue.sv
rtl/core/i2a_back.sv
rtl/core/integer_to_ascii_formatter_top.sv
rtl/core/i2a_checker.sv
tb/i2a_checker.sv
tb/tb.sv
